/* rtl/sip_pkg.sv */
// shared types and widths for the segment intersection point core
`default_nettype none
package sip_pkg;

    localparam int CRD_W = 16;
    localparam int DLT_W = CRD_W + 1;
    localparam int PRD_W = 2 * DLT_W;
    localparam int DEN_W = PRD_W + 1;
    localparam int NUM_W = CRD_W + DEN_W + 2;
    localparam int OUT_W = 24;
    localparam int DIV_LAT = OUT_W + 3;
    localparam int GEO_LAT = 5;

    typedef struct packed {
        logic signed [CRD_W-1:0] a_start_x;
        logic signed [CRD_W-1:0] a_start_y;
        logic signed [CRD_W-1:0] a_end_x;
        logic signed [CRD_W-1:0] a_end_y;
        logic signed [CRD_W-1:0] b_start_x;
        logic signed [CRD_W-1:0] b_start_y;
        logic signed [CRD_W-1:0] b_end_x;
        logic signed [CRD_W-1:0] b_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic                    hit;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } t_cross;

endpackage
`default_nettype wire

/* rtl/sip_geom.sv */
// geometry pipeline: deltas, cross products, hit test and crossing numerators
`default_nettype none
module sip_geom #(
    parameter int COORD_BITS = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_en,
    input  wire sip_pkg::t_seg_pair                i_data,
    output logic                                   o_hit,
    output logic signed [sip_pkg::NUM_W-1:0]       o_num_x,
    output logic signed [sip_pkg::NUM_W-1:0]       o_num_y,
    output logic signed [sip_pkg::DEN_W-1:0]       o_den
);
    import sip_pkg::*;

    localparam int EW = (COORD_BITS > CRD_W) ? CRD_W : COORD_BITS;
    localparam int SH = CRD_W - EW;

    logic signed [CRD_W-1:0] c [8];
    logic signed [CRD_W-1:0] raw [8];

    logic signed [CRD_W-1:0] r1_ax0, r1_ay0;
    logic signed [DLT_W-1:0] r1_dax, r1_day, r1_dbx, r1_dby, r1_wx, r1_wy;

    logic signed [CRD_W-1:0] r2_ax0, r2_ay0;
    logic signed [DLT_W-1:0] r2_dax, r2_day;
    logic signed [PRD_W-1:0] r2_p [6];

    logic signed [CRD_W-1:0] r3_ax0, r3_ay0;
    logic signed [DLT_W-1:0] r3_dax, r3_day;
    logic signed [DEN_W-1:0] r3_den, r3_tn, r3_sn;

    logic                    r4_hit;
    logic signed [DEN_W-1:0] r4_den;
    logic signed [NUM_W-1:0] r4_ax, r4_tx, r4_ay, r4_ty;

    logic                    r5_hit;
    logic signed [DEN_W-1:0] r5_den;
    logic signed [NUM_W-1:0] r5_nx, r5_ny;

    function automatic logic inside_open(logic signed [DEN_W-1:0] n,
                                         logic signed [DEN_W-1:0] d);
        if (d > 0) begin
            return (n > 0) && (n < d);
        end
        return (n < 0) && (n > d);
    endfunction

    assign raw[0] = i_data.a_start_x;
    assign raw[1] = i_data.a_start_y;
    assign raw[2] = i_data.a_end_x;
    assign raw[3] = i_data.a_end_y;
    assign raw[4] = i_data.b_start_x;
    assign raw[5] = i_data.b_start_y;
    assign raw[6] = i_data.b_end_x;
    assign raw[7] = i_data.b_end_y;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            c[k] = (raw[k] <<< SH) >>> SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax0 <= c[0];
            r1_ay0 <= c[1];
            r1_dax <= DLT_W'(c[2]) - DLT_W'(c[0]);
            r1_day <= DLT_W'(c[3]) - DLT_W'(c[1]);
            r1_dbx <= DLT_W'(c[6]) - DLT_W'(c[4]);
            r1_dby <= DLT_W'(c[7]) - DLT_W'(c[5]);
            r1_wx  <= DLT_W'(c[0]) - DLT_W'(c[4]);
            r1_wy  <= DLT_W'(c[1]) - DLT_W'(c[5]);

            r2_ax0  <= r1_ax0;
            r2_ay0  <= r1_ay0;
            r2_dax  <= r1_dax;
            r2_day  <= r1_day;
            r2_p[0] <= PRD_W'(r1_dby) * PRD_W'(r1_dax);
            r2_p[1] <= PRD_W'(r1_dbx) * PRD_W'(r1_day);
            r2_p[2] <= PRD_W'(r1_dbx) * PRD_W'(r1_wy);
            r2_p[3] <= PRD_W'(r1_dby) * PRD_W'(r1_wx);
            r2_p[4] <= PRD_W'(r1_dax) * PRD_W'(r1_wy);
            r2_p[5] <= PRD_W'(r1_day) * PRD_W'(r1_wx);

            r3_ax0 <= r2_ax0;
            r3_ay0 <= r2_ay0;
            r3_dax <= r2_dax;
            r3_day <= r2_day;
            r3_den <= DEN_W'(r2_p[0]) - DEN_W'(r2_p[1]);
            r3_tn  <= DEN_W'(r2_p[2]) - DEN_W'(r2_p[3]);
            r3_sn  <= DEN_W'(r2_p[4]) - DEN_W'(r2_p[5]);

            r4_hit <= inside_open(r3_tn, r3_den) && inside_open(r3_sn, r3_den);
            r4_den <= r3_den;
            r4_ax  <= NUM_W'(r3_ax0) * NUM_W'(r3_den);
            r4_tx  <= NUM_W'(r3_tn) * NUM_W'(r3_dax);
            r4_ay  <= NUM_W'(r3_ay0) * NUM_W'(r3_den);
            r4_ty  <= NUM_W'(r3_tn) * NUM_W'(r3_day);

            r5_hit <= r4_hit;
            r5_den <= r4_den;
            r5_nx  <= r4_ax + r4_tx;
            r5_ny  <= r4_ay + r4_ty;
        end
    end

    assign o_hit   = r5_hit;
    assign o_num_x = r5_nx;
    assign o_num_y = r5_ny;
    assign o_den   = r5_den;

endmodule
`default_nettype wire

/* rtl/sip_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating result, zero when i_keep is low
`default_nettype none
module sip_div #(
    parameter int FRAC_BITS = 8
) (
    input  wire                                    i_clk,
    input  wire                                    i_en,
    input  wire                                    i_keep,
    input  wire signed [sip_pkg::NUM_W-1:0]        i_num,
    input  wire signed [sip_pkg::DEN_W-1:0]        i_den,
    output logic signed [sip_pkg::OUT_W-1:0]       o_val
);
    import sip_pkg::*;

    localparam int Q_W   = OUT_W;
    localparam int REM_W = DEN_W + Q_W;
    localparam int NSH_W = NUM_W + FRAC_BITS;
    localparam int SH_W  = (NSH_W > REM_W) ? NSH_W : REM_W;
    localparam logic [Q_W-1:0] SAT = Q_W'(1) << (Q_W - 1);

    logic [NUM_W-1:0] r_nm;
    logic [DEN_W-1:0] r_dm;
    logic             r_neg0, r_keep0;

    logic [SH_W-1:0]  n_nsh, n_dsh;

    logic [REM_W-1:0] r_rem  [Q_W+1];
    logic [Q_W-1:0]   r_q    [Q_W+1];
    logic [DEN_W-1:0] r_d    [Q_W+1];
    logic             r_ovf  [Q_W+1];
    logic             r_neg  [Q_W+1];
    logic             r_keep [Q_W+1];

    logic [Q_W-1:0]        n_msat;
    logic signed [Q_W-1:0] n_val;
    logic signed [Q_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm    <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_dm    <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_neg0  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_keep0 <= i_keep;
        end
    end

    assign n_nsh = SH_W'(r_nm) << FRAC_BITS;
    assign n_dsh = SH_W'(r_dm) << Q_W;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_nsh[REM_W-1:0];
            r_q[0]    <= '0;
            r_d[0]    <= r_dm;
            r_ovf[0]  <= (n_nsh >= n_dsh);
            r_neg[0]  <= r_neg0;
            r_keep[0] <= r_keep0;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [REM_W-1:0] n_trial;
        logic             n_take;
        assign n_trial = REM_W'(r_d[k-1]) << (Q_W - k);
        assign n_take  = (r_rem[k-1] >= n_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_take ? (r_rem[k-1] - n_trial) : r_rem[k-1];
                r_q[k]    <= r_q[k-1] | (Q_W'(n_take) << (Q_W - k));
                r_d[k]    <= r_d[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_keep[k] <= r_keep[k-1];
            end
        end
    end

    always_comb begin
        n_msat = (r_ovf[Q_W] || (r_q[Q_W] > SAT)) ? SAT : r_q[Q_W];
        if (!r_keep[Q_W]) begin
            n_val = '0;
        end else if (r_neg[Q_W]) begin
            n_val = -$signed(n_msat);
        end else if (n_msat == SAT) begin
            n_val = $signed(SAT - Q_W'(1));
        end else begin
            n_val = $signed(n_msat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_val;
        end
    end

    assign o_val = r_out;

endmodule
`default_nettype wire

/* rtl/segment_intersection_point_core.sv */
// top level: segment pair in, crossing point out
// throughput: one segment pair per cycle while the output is not stalled
// a stall on the output freezes the whole pipeline; nothing is dropped
// reset: synchronous active low, clears all stage valid bits
`default_nettype none
module segment_intersection_point_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire sip_pkg::t_seg_pair i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output sip_pkg::t_cross     o_data
);
    import sip_pkg::*;

    localparam int TOT_LAT = GEO_LAT + DIV_LAT;

    logic                    n_en;
    logic                    g_hit;
    logic signed [NUM_W-1:0] g_nx, g_ny;
    logic signed [DEN_W-1:0] g_den;
    logic signed [OUT_W-1:0] d_x, d_y;

    logic [TOT_LAT-1:0] r_vld;
    logic [DIV_LAT-1:0] r_hit;

    assign n_en    = !r_vld[TOT_LAT-1] || i_ready;
    assign o_ready = n_en;

    sip_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_data  (i_data),
        .o_hit   (g_hit),
        .o_num_x (g_nx),
        .o_num_y (g_ny),
        .o_den   (g_den)
    );

    sip_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_keep (g_hit),
        .i_num  (g_nx),
        .i_den  (g_den),
        .o_val  (d_x)
    );

    sip_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_keep (g_hit),
        .i_num  (g_ny),
        .i_den  (g_den),
        .o_val  (d_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_hit <= {r_hit[DIV_LAT-2:0], g_hit};
        end
    end

    assign o_valid        = r_vld[TOT_LAT-1];
    assign o_data.hit     = r_hit[DIV_LAT-1];
    assign o_data.cross_x = d_x;
    assign o_data.cross_y = d_y;

endmodule
`default_nettype wire
